// ----- src/hvn_pkg.sv -----
package hvn_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    // register map, word index taken from paddr[2]
    localparam logic REG_SEED = 1'b0;

    localparam logic [DATA_W-1:0] SEED_RESET = 32'd123445454;

    // lattice hash constants
    localparam int                HASH_SHIFT = 13;
    localparam logic [DATA_W-1:0] HASH_MUL_A = 32'd60493;
    localparam logic [DATA_W-1:0] HASH_ADD_B = 32'd19990303;
    localparam logic [DATA_W-1:0] HASH_ADD_C = 32'd1376312589;
    localparam logic [DATA_W-1:0] HASH_MASK  = 32'h7fffffff;
    localparam logic [DATA_W-1:0] CORNER_ONE = 32'h40000000;

    // index offsets of the four corners: (0,0) (1,0) (0,1) (1,1), z stride 57
    localparam logic [DATA_W-1:0] OFS_00 = 32'd0;
    localparam logic [DATA_W-1:0] OFS_10 = 32'd1;
    localparam logic [DATA_W-1:0] OFS_01 = 32'd57;
    localparam logic [DATA_W-1:0] OFS_11 = 32'd58;

    // index stage, corner stage, hash (4), x lerp (2), z lerp (2)
    localparam int PIPE_DEPTH = 10;
    localparam int FX_DELAY   = 6;
    localparam int FZ_DELAY   = 8;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic [FRAC_BITS-1:0]     frac_t;

endpackage

// ----- src/hvn_cfg.sv -----
module hvn_cfg
    import hvn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [DATA_W-1:0] seed
);

    logic [DATA_W-1:0] seed_reg;
    logic [DATA_W-1:0] seed_next;
    logic              wr_seed;

    assign wr_seed   = psel && penable && pwrite && (paddr[2] == REG_SEED);
    assign seed_next = wr_seed ? pwdata : seed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
        end else begin
            seed_reg <= seed_next;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SEED: prdata = seed_reg;
            default:  prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign seed   = seed_reg;

endmodule

// ----- src/hvn_hash.sv -----
module hvn_hash
    import hvn_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [DATA_W-1:0] n_in,
    output sample_t           corner
);

    // four stages: n*n, *A+B, n*t, +C / mask / 1-x
    logic [DATA_W-1:0] sq_reg, sq_next;
    logic [DATA_W-1:0] n1_reg;
    logic [DATA_W-1:0] t_reg, t_next;
    logic [DATA_W-1:0] n2_reg;
    logic [DATA_W-1:0] p_reg, p_next;
    sample_t           corner_reg, corner_next;

    assign sq_next     = n_in * n_in;
    assign t_next      = sq_reg * HASH_MUL_A + HASH_ADD_B;
    assign p_next      = n2_reg * t_reg;
    assign corner_next = sample_t'(CORNER_ONE - ((p_reg + HASH_ADD_C) & HASH_MASK));

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg     <= sq_next;
            n1_reg     <= n_in;
            t_reg      <= t_next;
            n2_reg     <= n1_reg;
            p_reg      <= p_next;
            corner_reg <= corner_next;
        end
    end

    assign corner = corner_reg;

endmodule

// ----- src/hvn_lerp.sv -----
module hvn_lerp
    import hvn_pkg::*;
(
    input  logic    aclk,
    input  logic    en,
    input  sample_t a,
    input  sample_t b,
    input  frac_t   f,
    output sample_t y
);

    localparam int DIFF_W = DATA_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    // a*(1-f) + b*f == a*2^F + (b-a)*f, and the floor of the shift keeps a exact
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    sample_t                  a_reg;
    frac_t                    f_reg;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] sum;
    sample_t                  y_reg, y_next;

    assign diff_next = $signed({b[DATA_W-1], b}) - $signed({a[DATA_W-1], a});
    assign prod      = diff_reg * $signed({1'b0, f_reg});
    assign sum       = (prod >>> FRAC_BITS) + PROD_W'(a_reg);
    assign y_next    = sum[DATA_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= diff_next;
            a_reg    <= a;
            f_reg    <= f;
            y_reg    <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ----- src/hashed_value_noise_2d_unit.sv -----
// 2D value noise: each (x, z) sample in signed fixed point (FRAC_BITS fraction
// bits) is split into a floor lattice index and fraction, the four neighbor
// corners are hashed in parallel and blended bilinearly (x first, then z) to a
// Q2.30 result. The pipeline is ten register stages deep, and one sample is taken
// every cycle as long as m_ready keeps the output moving. The depth is set by
// the hash multipliers, at most one multiply per stage per corner. A stall at
// m_ready freezes the whole pipeline and s_ready follows it. The seed register
// sits at byte address 0 and should be written only while no samples are in
// flight.
module hashed_value_noise_2d_unit
    import hvn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    input  logic              s_valid,
    output logic              s_ready,
    input  sample_t           s_x_coord,
    input  sample_t           s_z_coord,

    output logic              m_valid,
    input  logic              m_ready,
    output sample_t           m_noise_value
);

    logic [DATA_W-1:0]     seed;
    logic                  adv;
    logic [PIPE_DEPTH-1:0] valid_reg, valid_next;

    sample_t               ix, iz;
    logic [DATA_W-1:0]     sa_reg, sa_next;
    logic [DATA_W-1:0]     iz57_reg, iz57_next;
    frac_t                 fx_reg [FX_DELAY];
    frac_t                 fz_reg [FZ_DELAY];

    logic [DATA_W-1:0]     base;
    logic [DATA_W-1:0]     pre_00, pre_10, pre_01, pre_11;
    logic [DATA_W-1:0]     n00_reg, n10_reg, n01_reg, n11_reg;
    logic [DATA_W-1:0]     n00_next, n10_next, n01_next, n11_next;

    sample_t               c00, c10, c01, c11;
    sample_t               r0, r1;

    hvn_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .seed    (seed)
    );

    assign adv        = !valid_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready    = adv && aresetn;
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    // arithmetic shift gives the floor index for negative coordinates too
    assign ix        = s_x_coord >>> FRAC_BITS;
    assign iz        = s_z_coord >>> FRAC_BITS;
    assign sa_next   = ix + seed;
    assign iz57_next = (iz << 6) - (iz << 3) + iz;

    assign base   = sa_reg + iz57_reg;
    assign pre_00 = base + OFS_00;
    assign pre_10 = base + OFS_10;
    assign pre_01 = base + OFS_01;
    assign pre_11 = base + OFS_11;

    assign n00_next = pre_00 ^ (pre_00 << HASH_SHIFT);
    assign n10_next = pre_10 ^ (pre_10 << HASH_SHIFT);
    assign n01_next = pre_01 ^ (pre_01 << HASH_SHIFT);
    assign n11_next = pre_11 ^ (pre_11 << HASH_SHIFT);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sa_reg    <= sa_next;
            iz57_reg  <= iz57_next;
            fx_reg[0] <= s_x_coord[FRAC_BITS-1:0];
            fz_reg[0] <= s_z_coord[FRAC_BITS-1:0];
            for (int i = 1; i < FX_DELAY; i++) begin
                fx_reg[i] <= fx_reg[i-1];
            end
            for (int i = 1; i < FZ_DELAY; i++) begin
                fz_reg[i] <= fz_reg[i-1];
            end
            n00_reg <= n00_next;
            n10_reg <= n10_next;
            n01_reg <= n01_next;
            n11_reg <= n11_next;
        end
    end

    hvn_hash u_hash_00 (.aclk(aclk), .en(adv), .n_in(n00_reg), .corner(c00));
    hvn_hash u_hash_10 (.aclk(aclk), .en(adv), .n_in(n10_reg), .corner(c10));
    hvn_hash u_hash_01 (.aclk(aclk), .en(adv), .n_in(n01_reg), .corner(c01));
    hvn_hash u_hash_11 (.aclk(aclk), .en(adv), .n_in(n11_reg), .corner(c11));

    hvn_lerp u_lerp_x0 (
        .aclk (aclk),
        .en   (adv),
        .a    (c00),
        .b    (c10),
        .f    (fx_reg[FX_DELAY-1]),
        .y    (r0)
    );

    hvn_lerp u_lerp_x1 (
        .aclk (aclk),
        .en   (adv),
        .a    (c01),
        .b    (c11),
        .f    (fx_reg[FX_DELAY-1]),
        .y    (r1)
    );

    hvn_lerp u_lerp_z (
        .aclk (aclk),
        .en   (adv),
        .a    (r0),
        .b    (r1),
        .f    (fz_reg[FZ_DELAY-1]),
        .y    (m_noise_value)
    );

    assign m_valid = valid_reg[PIPE_DEPTH-1];

endmodule
